// ----- hw/rtl/hsf_pkg.sv -----
`default_nettype none

package hsf_pkg;

    // Geometry and counter sizing.
    localparam int COORD_BITS = 16;
    localparam int MAX_POINTS = 4096;
    localparam int IDX_W      = 12;
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

    // Exact widths of the arithmetic chain.
    localparam int DIFF_W  = COORD_BITS + 1;     // coordinate difference
    localparam int MUL_W   = 2 * DIFF_W;         // one cross product term
    localparam int NORM_W  = MUL_W + 1;          // normal component
    localparam int DPROD_W = DIFF_W + NORM_W;    // one dot product term
    localparam int DOT_W   = DPROD_W + 2;        // sum of three terms

    // Cycles from a vertex register write to a settled normal.
    localparam int NORM_LAT = 3;
    localparam int BUSY_W   = $clog2(NORM_LAT + 1);

    // Request codes.
    localparam logic       MODE_VERTEX = 1'b0;
    localparam logic       MODE_POINT  = 1'b1;
    localparam logic [1:0] SLOT_A      = 2'd0;
    localparam logic [1:0] SLOT_B      = 2'd1;
    localparam logic [1:0] SLOT_C      = 2'd2;
    localparam logic [1:0] SLOT_NONE   = 2'd3;

    typedef struct packed {
        logic                           en;
        logic [1:0]                     slot;
        logic [IDX_W-1:0]               idx;
        logic [2:0][COORD_BITS-1:0]     p;
    } vtx_wr_t;

    typedef struct packed {
        logic [2:0][COORD_BITS-1:0]     a;
        logic [2:0][IDX_W-1:0]          ids;
        logic [2:0][NORM_W-1:0]         normal;
        logic                           busy;
    } face_t;

    typedef struct packed {
        logic                           valid;
        logic                           point;
        logic [IDX_W-1:0]               idx;
        logic [2:0][DPROD_W-1:0]        prod;
    } st3_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsf_face.sv -----
`default_nettype none

// Face vertex store and a three-stage pipeline that keeps the normal up to date.
module hsf_face (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hsf_pkg::vtx_wr_t wr,
    output hsf_pkg::face_t       face
);

    logic [2:0][hsf_pkg::COORD_BITS-1:0] vert_reg  [3];
    logic [2:0][hsf_pkg::COORD_BITS-1:0] vert_next [3];
    logic [2:0][hsf_pkg::IDX_W-1:0]      ids_reg;
    logic [2:0][hsf_pkg::IDX_W-1:0]      ids_next;

    logic signed [hsf_pkg::DIFF_W-1:0] u_reg [3];
    logic signed [hsf_pkg::DIFF_W-1:0] u_next [3];
    logic signed [hsf_pkg::DIFF_W-1:0] w_reg [3];
    logic signed [hsf_pkg::DIFF_W-1:0] w_next [3];
    logic signed [hsf_pkg::MUL_W-1:0]  m_reg [6];
    logic signed [hsf_pkg::MUL_W-1:0]  m_next [6];
    logic signed [hsf_pkg::NORM_W-1:0] n_reg [3];
    logic signed [hsf_pkg::NORM_W-1:0] n_next [3];
    logic [hsf_pkg::BUSY_W-1:0]        busy_reg;
    logic [hsf_pkg::BUSY_W-1:0]        busy_next;

    always_comb
    begin
        vert_next = vert_reg;
        ids_next  = ids_reg;
        if (wr.en)
        begin
            case (wr.slot)
                hsf_pkg::SLOT_A:
                begin
                    vert_next[0] = wr.p;
                    ids_next[0]  = wr.idx;
                end
                hsf_pkg::SLOT_B:
                begin
                    vert_next[1] = wr.p;
                    ids_next[1]  = wr.idx;
                end
                hsf_pkg::SLOT_C:
                begin
                    vert_next[2] = wr.p;
                    ids_next[2]  = wr.idx;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Edge vectors b - a and c - a.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u_next[k] = hsf_pkg::DIFF_W'($signed(vert_reg[1][k]))
                      - hsf_pkg::DIFF_W'($signed(vert_reg[0][k]));
            w_next[k] = hsf_pkg::DIFF_W'($signed(vert_reg[2][k]))
                      - hsf_pkg::DIFF_W'($signed(vert_reg[0][k]));
        end
    end

    // Cross product terms, then their differences.
    assign m_next[0] = hsf_pkg::MUL_W'(u_reg[1]) * hsf_pkg::MUL_W'(w_reg[2]);
    assign m_next[1] = hsf_pkg::MUL_W'(u_reg[2]) * hsf_pkg::MUL_W'(w_reg[1]);
    assign m_next[2] = hsf_pkg::MUL_W'(u_reg[2]) * hsf_pkg::MUL_W'(w_reg[0]);
    assign m_next[3] = hsf_pkg::MUL_W'(u_reg[0]) * hsf_pkg::MUL_W'(w_reg[2]);
    assign m_next[4] = hsf_pkg::MUL_W'(u_reg[0]) * hsf_pkg::MUL_W'(w_reg[1]);
    assign m_next[5] = hsf_pkg::MUL_W'(u_reg[1]) * hsf_pkg::MUL_W'(w_reg[0]);

    assign n_next[0] = hsf_pkg::NORM_W'(m_reg[0]) - hsf_pkg::NORM_W'(m_reg[1]);
    assign n_next[1] = hsf_pkg::NORM_W'(m_reg[2]) - hsf_pkg::NORM_W'(m_reg[3]);
    assign n_next[2] = hsf_pkg::NORM_W'(m_reg[4]) - hsf_pkg::NORM_W'(m_reg[5]);

    // The normal is stale until the write has run through all three stages.
    always_comb
    begin
        if (wr.en)
            busy_next = hsf_pkg::BUSY_W'(hsf_pkg::NORM_LAT);
        else if (busy_reg != '0)
            busy_next = busy_reg - hsf_pkg::BUSY_W'(1);
        else
            busy_next = busy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                vert_reg[k] <= '0;
                u_reg[k]    <= '0;
                w_reg[k]    <= '0;
                n_reg[k]    <= '0;
            end
            for (int k = 0; k < 6; k++)
            begin
                m_reg[k] <= '0;
            end
            ids_reg  <= '0;
            busy_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                vert_reg[k] <= vert_next[k];
                u_reg[k]    <= u_next[k];
                w_reg[k]    <= w_next[k];
                n_reg[k]    <= n_next[k];
            end
            for (int k = 0; k < 6; k++)
            begin
                m_reg[k] <= m_next[k];
            end
            ids_reg  <= ids_next;
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        face.a    = vert_reg[0];
        face.ids  = ids_reg;
        face.busy = (busy_reg != '0);
        for (int k = 0; k < 3; k++)
        begin
            face.normal[k] = n_reg[k];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hsf_front.sv -----
`default_nettype none

// Input register, difference stage and product stage of the point test.
module hsf_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           valid,
    output logic                                ready,
    input  wire logic                           mode,
    input  wire logic [1:0]                     slot,
    input  wire logic [hsf_pkg::IDX_W-1:0]      point_index,
    input  wire logic signed [hsf_pkg::COORD_BITS-1:0] coord_x,
    input  wire logic signed [hsf_pkg::COORD_BITS-1:0] coord_y,
    input  wire logic signed [hsf_pkg::COORD_BITS-1:0] coord_z,
    input  wire hsf_pkg::face_t                 face,
    input  wire logic                           take,
    output hsf_pkg::vtx_wr_t                    wr,
    output hsf_pkg::st3_t                       st3
);

    logic                                   v1_reg, v1_next;
    logic                                   mode1_reg;
    logic [1:0]                             slot1_reg;
    logic [hsf_pkg::IDX_W-1:0]              idx1_reg;
    logic [2:0][hsf_pkg::COORD_BITS-1:0]    p1_reg;

    logic                                   v2_reg, v2_next;
    logic                                   point2_reg;
    logic [hsf_pkg::IDX_W-1:0]              idx2_reg;
    logic [2:0][hsf_pkg::DIFF_W-1:0]        d2_reg;
    logic [2:0][hsf_pkg::DIFF_W-1:0]        d2_next;

    logic                                   v3_reg, v3_next;
    logic                                   point3_reg;
    logic [hsf_pkg::IDX_W-1:0]              idx3_reg;
    logic [2:0][hsf_pkg::DPROD_W-1:0]       prod3_reg;
    logic [2:0][hsf_pkg::DPROD_W-1:0]       prod3_next;

    logic en2, en3, adv1, adv2, acc, keep1, hit;

    // A stage takes a new entry when it is empty or its entry moves on.
    // Entries wait before the multiply while the normal is being rebuilt.
    assign en3   = !v3_reg || take;
    assign en2   = !v2_reg || (en3 && !face.busy);
    assign adv2  = v2_reg && en3 && !face.busy;
    assign adv1  = v1_reg && en2;
    assign ready = !v1_reg || en2;
    assign acc   = valid && ready;

    // A vertex load for the unused slot leaves no trace.
    assign keep1 = (mode1_reg == hsf_pkg::MODE_POINT) || (slot1_reg != hsf_pkg::SLOT_NONE);

    assign wr.en   = adv1 && (mode1_reg == hsf_pkg::MODE_VERTEX)
                   && (slot1_reg != hsf_pkg::SLOT_NONE);
    assign wr.slot = slot1_reg;
    assign wr.idx  = idx1_reg;
    assign wr.p    = p1_reg;

    assign hit = (idx1_reg == face.ids[0]) || (idx1_reg == face.ids[1])
              || (idx1_reg == face.ids[2]);

    // A point that carries the index of a face vertex gets a zero offset, so its dot product is zero.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (hit)
                d2_next[k] = '0;
            else
                d2_next[k] = hsf_pkg::DIFF_W'($signed(p1_reg[k]))
                           - hsf_pkg::DIFF_W'($signed(face.a[k]));
            prod3_next[k] = hsf_pkg::DPROD_W'($signed(d2_reg[k]))
                          * hsf_pkg::DPROD_W'($signed(face.normal[k]));
        end
    end

    assign v1_next = acc || (v1_reg && !adv1);
    assign v2_next = (adv1 && keep1) || (v2_reg && !adv2);
    assign v3_next = adv2 || (v3_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            mode1_reg <= mode;
            slot1_reg <= slot;
            idx1_reg  <= point_index;
            p1_reg    <= {coord_z, coord_y, coord_x};
        end
        if (adv1)
        begin
            point2_reg <= mode1_reg;
            idx2_reg   <= idx1_reg;
            d2_reg     <= d2_next;
        end
        if (adv2)
        begin
            point3_reg <= point2_reg;
            idx3_reg   <= idx2_reg;
            prod3_reg  <= prod3_next;
        end
    end

    assign st3.valid = v3_reg;
    assign st3.point = point3_reg;
    assign st3.idx   = idx3_reg;
    assign st3.prod  = prod3_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/half_space_point_filter_top.sv -----
`default_nettype none

// Half-space point filter: tests points against the plane of one triangle face.
//
// Request channel (point_valid / point_ready): a request with mode 0 loads face
// vertex a, b or c (slot 0, 1, 2) with its index and coordinates; slot 3 is
// dropped. Every vertex load rebuilds the normal (b - a) x (c - a) and clears
// the candidate count. A request with mode 1 tests one point.
// Result channel (result_valid / result_ready): one result per point request,
// in order, with the point index, the above flag and the running count of
// points found above since the last vertex load. Vertex loads give no result.
//
// Points stream at one per cycle while the receiver keeps up and no normal
// is being rebuilt. After a vertex load, the first point behind it waits in
// front of the multiply stage until the three-stage normal pipeline has
// settled. When the receiver stalls, the result register holds its result
// and the stages behind it keep filling; point_ready drops only when the
// input and difference stages both hold entries that cannot move on.
// Reset clears the face to all zero, the count to zero and empties the stages.
module half_space_point_filter_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  point_valid,
    output logic                                       point_ready,
    input  wire logic                                  mode,
    input  wire logic [1:0]                            slot,
    input  wire logic [hsf_pkg::IDX_W-1:0]             point_index,
    input  wire logic signed [hsf_pkg::COORD_BITS-1:0] coord_x,
    input  wire logic signed [hsf_pkg::COORD_BITS-1:0] coord_y,
    input  wire logic signed [hsf_pkg::COORD_BITS-1:0] coord_z,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output logic [hsf_pkg::IDX_W-1:0]                  tested_index,
    output logic                                       above,
    output logic [hsf_pkg::COUNT_W-1:0]                candidate_count
);

    hsf_pkg::vtx_wr_t wr;
    hsf_pkg::face_t   face;
    hsf_pkg::st3_t    st3;

    logic                              rv_reg, rv_next;
    logic [hsf_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [hsf_pkg::IDX_W-1:0]         idx_reg;
    logic                              above_reg;
    logic [hsf_pkg::COUNT_W-1:0]       cnt_out_reg;

    logic                              en_o, take, pos, abv;
    logic signed [hsf_pkg::DOT_W-1:0]  dot;

    hsf_face u_face (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .face  (face)
    );

    hsf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (point_valid),
        .ready       (point_ready),
        .mode        (mode),
        .slot        (slot),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .face        (face),
        .take        (take),
        .wr          (wr),
        .st3         (st3)
    );

    // The result register takes a new entry when empty or when its result leaves.
    assign en_o = !rv_reg || result_ready;
    assign take = st3.valid && en_o;

    // Exact sign of the dot product: strictly positive means above the face.
    assign dot = hsf_pkg::DOT_W'($signed(st3.prod[0]))
               + hsf_pkg::DOT_W'($signed(st3.prod[1]))
               + hsf_pkg::DOT_W'($signed(st3.prod[2]));
    assign pos = !dot[hsf_pkg::DOT_W-1] && (dot != '0);
    assign abv = st3.point && pos;

    // The vertex load travels down the stages as a marker, so the count clears
    // after every earlier point has been counted and before any later one.
    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            if (!st3.point)
                count_next = '0;
            else if (abv && (count_reg < hsf_pkg::COUNT_W'(hsf_pkg::MAX_POINTS)))
                count_next = count_reg + hsf_pkg::COUNT_W'(1);
        end
    end

    assign rv_next = take ? st3.point : (rv_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg    <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            rv_reg    <= rv_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && st3.point)
        begin
            idx_reg     <= st3.idx;
            above_reg   <= abv;
            cnt_out_reg <= count_next;
        end
    end

    assign result_valid    = rv_reg;
    assign tested_index    = idx_reg;
    assign above           = above_reg;
    assign candidate_count = cnt_out_reg;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;

    // Run-time knobs. The cycle limit sits far above the slowest legal run:
    // about two thousand requests, each paying at most a sender gap, a
    // normal rebuild, a receiver that takes one result in four, plus one long
    // receiver hold.
    localparam int          CLK_HALF          = 5;
    localparam int          RESET_CYCLES      = 8;
    localparam int unsigned CYCLE_LIMIT       = 1_000_000;
    localparam int          TAIL_CYCLES       = 20;
    localparam int          LONG_HOLD_CYCLES  = 300;
    localparam int          RANDOM_REQUESTS   = 2000;

    localparam logic signed [hsf_pkg::COORD_BITS-1:0] CMAX =
        {1'b0, {(hsf_pkg::COORD_BITS-1){1'b1}}};
    localparam logic signed [hsf_pkg::COORD_BITS-1:0] CMIN =
        {1'b1, {(hsf_pkg::COORD_BITS-1){1'b0}}};
    localparam logic [hsf_pkg::IDX_W-1:0]             IMAX = {hsf_pkg::IDX_W{1'b1}};

    // One expected result of a point request.
    typedef struct {
        logic [hsf_pkg::IDX_W-1:0]   index;
        logic                        hit;
        logic [hsf_pkg::COUNT_W-1:0] count;
    } point_verdict_t;

    // Receiver behaviors; each one runs for a random stretch of cycles.
    typedef enum {RX_OPEN, RX_MOSTLY, RX_STINGY, RX_ALTERNATE} rx_style_t;

    // Keeps its own copy of the face, the normal and the running count, and
    // the queue of verdicts still owed by the block. Coordinates are held as
    // 64-bit integers: the dot product needs about 51 bits, so it is exact.
    class half_space_scoreboard;
        longint                    vertex_pos[3][3];
        logic [hsf_pkg::IDX_W-1:0] vertex_id[3];
        longint                    plane_normal[3];
        int unsigned               above_count;
        point_verdict_t            expected_verdicts[$];
        int                        error_count;

        function new();
            for (int s = 0; s < 3; s++)
            begin
                vertex_id[s]    = '0;
                plane_normal[s] = 0;
                for (int k = 0; k < 3; k++)
                    vertex_pos[s][k] = 0;
            end
            above_count = 0;
            error_count = 0;
        endfunction

        function void note_request(input logic req_mode, input logic [1:0] req_slot,
                                   input logic [hsf_pkg::IDX_W-1:0] req_index,
                                   input longint px, input longint py, input longint pz);
            longint         pos[3];
            longint         u[3];
            longint         w[3];
            longint         dot;
            point_verdict_t v;
            int             s;
            pos[0] = px;
            pos[1] = py;
            pos[2] = pz;
            if (req_mode == hsf_pkg::MODE_VERTEX)
            begin
                // Slot three is dropped by the block without any effect.
                if (req_slot == hsf_pkg::SLOT_NONE)
                    return;
                s = int'(req_slot);
                vertex_id[s] = req_index;
                for (int k = 0; k < 3; k++)
                    vertex_pos[s][k] = pos[k];
                for (int k = 0; k < 3; k++)
                begin
                    u[k] = vertex_pos[1][k] - vertex_pos[0][k];
                    w[k] = vertex_pos[2][k] - vertex_pos[0][k];
                end
                plane_normal[0] = u[1] * w[2] - u[2] * w[1];
                plane_normal[1] = u[2] * w[0] - u[0] * w[2];
                plane_normal[2] = u[0] * w[1] - u[1] * w[0];
                above_count = 0;
                return;
            end
            v.index = req_index;
            v.hit   = 1'b0;
            // A point that carries one of the face indices is never above.
            if (req_index != vertex_id[0] && req_index != vertex_id[1] &&
                req_index != vertex_id[2])
            begin
                dot = 0;
                for (int k = 0; k < 3; k++)
                    dot += (pos[k] - vertex_pos[0][k]) * plane_normal[k];
                v.hit = (dot > 0);
            end
            if (v.hit && above_count < hsf_pkg::MAX_POINTS)
                above_count++;
            v.count = hsf_pkg::COUNT_W'(above_count);
            expected_verdicts.insert(expected_verdicts.size(), v);
        endfunction

        function void match_result(input logic [hsf_pkg::IDX_W-1:0] got_index,
                                   input logic got_hit,
                                   input logic [hsf_pkg::COUNT_W-1:0] got_count);
            point_verdict_t v;
            if (expected_verdicts.size() == 0)
            begin
                $error("result with nothing pending: tested_index %0d", got_index);
                error_count++;
                return;
            end
            v = expected_verdicts.pop_front();
            if (got_index !== v.index)
            begin
                $error("tested_index: expected %0d, actual %0d", v.index, got_index);
                error_count++;
            end
            if (got_hit !== v.hit)
            begin
                $error("above: expected %0d, actual %0d", v.hit, got_hit);
                error_count++;
            end
            if (got_count !== v.count)
            begin
                $error("candidate_count: expected %0d, actual %0d", v.count, got_count);
                error_count++;
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic                                  clk             = 1'b0;
    logic                                  rst_n           = 1'b0;
    logic                                  point_valid     = 1'b0;
    logic                                  point_ready;
    logic                                  mode            = hsf_pkg::MODE_VERTEX;
    logic [1:0]                            slot            = hsf_pkg::SLOT_A;
    logic [hsf_pkg::IDX_W-1:0]             point_index     = '0;
    logic signed [hsf_pkg::COORD_BITS-1:0] coord_x         = '0;
    logic signed [hsf_pkg::COORD_BITS-1:0] coord_y         = '0;
    logic signed [hsf_pkg::COORD_BITS-1:0] coord_z         = '0;
    logic                                  result_valid;
    logic                                  result_ready    = 1'b0;
    logic [hsf_pkg::IDX_W-1:0]             tested_index;
    logic                                  above;
    logic [hsf_pkg::COUNT_W-1:0]           candidate_count;

    half_space_scoreboard board = new();

    // Sender pacing: requests go out in bursts; a gap of random length comes
    // before each new burst.
    int burst_left    = 0;
    int requests_sent = 0;

    // Set by the stimulus to ask the receiver for one long hold-off; the
    // receiver counts the hold itself and clears the flag.
    bit hold_pending = 1'b0;

    int unsigned cycle_count = 0;

    half_space_point_filter_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .point_valid     (point_valid),
        .point_ready     (point_ready),
        .mode            (mode),
        .slot            (slot),
        .point_index     (point_index),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .tested_index    (tested_index),
        .above           (above),
        .candidate_count (candidate_count)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge, before any of this edge's
    // nonblocking updates land, so the values seen are the ones the block saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point_valid && point_ready)
                board.note_request(mode, slot, point_index, longint'(coord_x),
                                   longint'(coord_y), longint'(coord_z));
            if (result_valid && result_ready)
                board.match_result(tested_index, above, candidate_count);
        end
    end

    // Receiver. It switches between a few behaviors, each for a random number
    // of cycles, so stalls land on every stage of the pipeline. A requested
    // long hold keeps result_ready low long enough for the stages to fill up
    // and push back on the request side.
    initial
    begin
        rx_style_t rx_style;
        int        rx_left;
        logic      take;
        rx_style = RX_OPEN;
        rx_left  = 0;
        take     = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (rx_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       rx_style = RX_OPEN;
                        1:       rx_style = RX_MOSTLY;
                        2:       rx_style = RX_STINGY;
                        default: rx_style = RX_ALTERNATE;
                    endcase
                    rx_left = $urandom_range(8, 120);
                end
                rx_left--;
                case (rx_style)
                    RX_OPEN:   take = 1'b1;
                    RX_MOSTLY: take = ($urandom_range(0, 3) != 0);
                    RX_STINGY: take = ($urandom_range(0, 3) == 0);
                    default:   take = ~take;
                endcase
                result_ready <= take;
                @(posedge clk);
            end
        end
    end

    // Offers one request and returns at the edge where it is accepted. The
    // caller is always at a rising edge, so the request is driven exactly once here.
    task automatic send_request(input logic m, input logic [1:0] s,
                                input logic [hsf_pkg::IDX_W-1:0] idx,
                                input logic signed [hsf_pkg::COORD_BITS-1:0] x,
                                input logic signed [hsf_pkg::COORD_BITS-1:0] y,
                                input logic signed [hsf_pkg::COORD_BITS-1:0] z);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                point_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        point_valid <= 1'b1;
        mode        <= m;
        slot        <= s;
        point_index <= idx;
        coord_x     <= x;
        coord_y     <= y;
        coord_z     <= z;
        do @(posedge clk); while (!point_ready);
        if (!(m == hsf_pkg::MODE_VERTEX && s == hsf_pkg::SLOT_NONE))
            requests_sent++;
    endtask

    // Stops offering requests until every owed result has come back.
    task automatic wait_drained();
        point_valid <= 1'b0;
        do @(posedge clk); while (board.expected_verdicts.size() != 0);
    endtask

    // Full-range value when span is zero, else a value near center.
    function automatic logic signed [hsf_pkg::COORD_BITS-1:0] pick_coord(input int center,
                                                                         input int span);
        int v;
        if (span == 0)
            return hsf_pkg::COORD_BITS'($urandom());
        v = center + int'($urandom_range(0, 2 * span)) - span;
        if (v > int'(CMAX))
            v = int'(CMAX);
        if (v < int'(CMIN))
            v = int'(CMIN);
        return hsf_pkg::COORD_BITS'(v);
    endfunction

    // Hand-picked requests: extreme coordinates and indices, the dropped slot,
    // a point carrying a face index, a point on the plane, a flipped face and a
    // degenerate face.
    task automatic run_directed();
        // Right after reset the face is all zero, so nothing can be above.
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_A, 12'd7, CMAX, CMAX, CMAX);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_NONE, 12'd0, CMIN, CMAX, CMIN);
        // A load into slot three must leave the face untouched.
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_NONE, IMAX, CMIN, CMIN, CMIN);
        // Corners of the cube; the normal points along +z.
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_A, IMAX, CMIN, CMIN, CMIN);
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_B, 12'd1, CMAX, CMIN, CMIN);
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_C, 12'd2, CMIN, CMAX, CMIN);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_A, 12'd0, CMAX, CMAX, CMAX);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_B, 12'd100,
                     16'sd0, 16'sd0, CMIN);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_C, IMAX, CMAX, CMAX, CMAX);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_NONE, 12'd2, CMAX, CMAX, CMAX);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_A, 12'd3000,
                     CMIN, CMIN, -16'sd32767);
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_NONE, 12'd5, CMAX, CMAX, CMAX);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_A, IMAX - 12'd1,
                     16'sd1, 16'sd1, 16'sd1);
        // Swapping b and c flips the normal and clears the count.
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_B, 12'd2, CMIN, CMAX, CMIN);
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_C, 12'd1, CMAX, CMIN, CMIN);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_A, 12'd10, CMAX, CMAX, CMAX);
        // Largest normal in all three components at once.
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_A, 12'd11, CMAX, CMIN, CMIN);
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_B, 12'd12, CMIN, CMAX, CMIN);
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_C, 12'd13, CMIN, CMIN, CMAX);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_A, 12'd14, CMAX, CMAX, CMAX);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_A, 12'd15, CMIN, CMIN, CMIN);
        // All three vertices on one spot: zero normal, nothing above.
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_B, 12'd12, CMAX, CMIN, CMIN);
        send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_C, 12'd13, CMAX, CMIN, CMIN);
        send_request(hsf_pkg::MODE_POINT, hsf_pkg::SLOT_A, 12'd16, CMAX, CMAX, CMAX);
    endtask

    // Random faces, each followed by a stream of points. Faces are built at
    // several scales so that points fall on both sides of the plane and now and
    // then exactly on it. A share of the traffic is noise: dropped slot-three
    // loads, faces only partly reloaded and stray vertex loads inside a stream.
    task automatic run_random_faces(input int budget);
        logic [hsf_pkg::IDX_W-1:0]             ids[3];
        logic signed [hsf_pkg::COORD_BITS-1:0] vpos[3][3];
        logic signed [hsf_pkg::COORD_BITS-1:0] pos[3];
        logic [1:0]                            order[3];
        logic [1:0]                            tmp_slot;
        logic [hsf_pkg::IDX_W-1:0]             idx;
        int                                    center[3];
        int                                    span;
        int                                    n_loads;
        int                                    n_points;
        int                                    pick;
        bit                                    pressure_done;
        pressure_done = 1'b0;
        for (int s = 0; s < 3; s++)
        begin
            ids[s] = '0;
            for (int k = 0; k < 3; k++)
                vpos[s][k] = '0;
        end
        while (requests_sent < budget)
        begin
            case ($urandom_range(0, 3))
                0:       span = 0;
                1:       span = 8;
                2:       span = 300;
                default: span = 6000;
            endcase
            for (int k = 0; k < 3; k++)
                center[k] = int'($urandom_range(0, 65535)) - 32768;
            order[0] = hsf_pkg::SLOT_A;
            order[1] = hsf_pkg::SLOT_B;
            order[2] = hsf_pkg::SLOT_C;
            for (int j = 2; j > 0; j--)
            begin
                pick        = $urandom_range(0, j);
                tmp_slot    = order[j];
                order[j]    = order[pick];
                order[pick] = tmp_slot;
            end
            n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 3;
            for (int j = 0; j < n_loads; j++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(hsf_pkg::MODE_VERTEX, hsf_pkg::SLOT_NONE,
                                 hsf_pkg::IDX_W'($urandom()),
                                 hsf_pkg::COORD_BITS'($urandom()),
                                 hsf_pkg::COORD_BITS'($urandom()),
                                 hsf_pkg::COORD_BITS'($urandom()));
                ids[order[j]] = hsf_pkg::IDX_W'($urandom());
                for (int k = 0; k < 3; k++)
                    vpos[order[j]][k] = pick_coord(center[k], span);
                send_request(hsf_pkg::MODE_VERTEX, order[j], ids[order[j]],
                             vpos[order[j]][0], vpos[order[j]][1], vpos[order[j]][2]);
            end

            n_points = $urandom_range(4, 40);

            // Halfway through, hold the receiver off for a long stretch while a
            // long run of points keeps coming back to back, so the block backs up.
            if (!pressure_done && requests_sent > budget / 2)
            begin
                pressure_done = 1'b1;
                hold_pending  = 1'b1;
                burst_left    = 80;
                n_points      = 60;
            end

            for (int j = 0; j < n_points; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                    idx = ids[$urandom_range(0, 2)];
                else
                    idx = hsf_pkg::IDX_W'($urandom());
                pick = $urandom_range(0, 15);
                for (int k = 0; k < 3; k++)
                begin
                    if (pick == 0)
                        pos[k] = vpos[0][k];
                    else if (pick == 1)
                        pos[k] = $urandom_range(0, 1) ? CMAX : CMIN;
                    else
                        pos[k] = pick_coord(center[k], span);
                end
                // A stray vertex load in the middle of a stream.
                if ($urandom_range(0, 39) == 0)
                begin
                    tmp_slot = 2'($urandom_range(0, 3));
                    if (tmp_slot != hsf_pkg::SLOT_NONE)
                    begin
                        ids[tmp_slot] = hsf_pkg::IDX_W'($urandom());
                        for (int k = 0; k < 3; k++)
                            vpos[tmp_slot][k] = pick_coord(center[k], span);
                    end
                    send_request(hsf_pkg::MODE_VERTEX, tmp_slot, ids[tmp_slot % 3],
                                 vpos[tmp_slot % 3][0], vpos[tmp_slot % 3][1],
                                 vpos[tmp_slot % 3][2]);
                end
                // The slot field is unused by a point request; vary it anyway.
                send_request(hsf_pkg::MODE_POINT, 2'($urandom_range(0, 3)), idx,
                             pos[0], pos[1], pos[2]);
            end
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        run_random_faces(requests_sent + RANDOM_REQUESTS);

        // Let the pipeline settle after the last result before judging.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.error_count == 0 && board.expected_verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- half_space_point_filter_top.f -----
hw/rtl/hsf_pkg.sv
hw/rtl/hsf_face.sv
hw/rtl/hsf_front.sv
hw/rtl/half_space_point_filter_top.sv
verif/tb_top.sv
